FILE: rtl/dspv_pkg.sv
package dspv_pkg;

  // default accumulator width
  localparam int VALUE_BITS_DEF = 12;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_YEAR = 2'd1;
  localparam logic [CFG_DATA_BITS-1:0] MIN_YEAR_RST = 12'd1900;
  localparam logic [CFG_DATA_BITS-1:0] MAX_YEAR_RST = 12'd2199;

  // field being read
  localparam logic [1:0] FIELD_DAY   = 2'd0;
  localparam logic [1:0] FIELD_MONTH = 2'd1;
  localparam logic [1:0] FIELD_YEAR  = 2'd2;

  // position within one number
  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } out_item_t;

  // parser status handed to the checker
  typedef struct packed {
    logic       dots_ok;
    logic [2:0] neg;
    logic       leap;
  } parse_flags_t;

endpackage

FILE: rtl/dspv_parse.sv
module dspv_parse #(
  parameter int VALUE_BITS = dspv_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  dspv_pkg::in_item_t     item,
  output logic [VALUE_BITS-1:0]  day_upd,
  output logic [VALUE_BITS-1:0]  month_upd,
  output logic [VALUE_BITS-1:0]  year_upd,
  output dspv_pkg::parse_flags_t flags
);
  import dspv_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + 4;
  localparam int VALUE_MAX = (1 << VALUE_BITS) - 1;
  localparam logic [VALUE_BITS-1:0] VAL_SAT = VALUE_BITS'(VALUE_MAX);
  localparam logic [8:0] SAT_MOD400 = 9'(VALUE_MAX % 400);
  localparam logic [5:0] SAT_MOD40  = 6'(VALUE_MAX % 40);

  logic [1:0]            field_r, field_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] day_r, month_r, year_r;
  logic [2:0]            neg_r, neg_nxt;
  logic                  ended_r, ended_nxt;
  // year remainders, kept alongside the year so the leap test needs no divider
  logic [8:0]            ymod400_r, ymod400_nxt;
  logic [5:0]            ymod40_r, ymod40_nxt;

  logic [VALUE_BITS-1:0] acc, acc_new;
  logic [PROD_BITS-1:0]  prod;
  logic [3:0]            digit;
  logic                  is_digit, is_blank, sat;
  logic [7:0]            c;

  always_comb begin
    c        = item.char_code;
    digit    = c[3:0];
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    case (field_r)
      FIELD_DAY:   acc = day_r;
      FIELD_MONTH: acc = month_r;
      default:     acc = year_r;
    endcase
    prod    = (PROD_BITS'(acc) << 3) + (PROD_BITS'(acc) << 1) + PROD_BITS'(digit);
    sat     = prod > PROD_BITS'(VALUE_MAX);
    acc_new = sat ? VAL_SAT : prod[VALUE_BITS-1:0];
  end

  always_comb begin
    field_nxt   = field_r;
    phase_nxt   = phase_r;
    day_upd     = day_r;
    month_upd   = month_r;
    year_upd    = year_r;
    neg_nxt     = neg_r;
    ended_nxt   = ended_r;
    ymod400_nxt = ymod400_r;
    ymod40_nxt  = ymod40_r;
    if (!ended_r) begin
      if (c == CH_NUL) begin
        ended_nxt = 1'b1;
      end else if ((c == CH_DOT) && (field_r != FIELD_YEAR)) begin
        field_nxt = field_r + 2'd1;
        phase_nxt = PH_BLANK;
      end else if (phase_r == PH_STOP) begin
        phase_nxt = PH_STOP;
      end else if (is_digit) begin
        phase_nxt = PH_DIGIT;
        case (field_r)
          FIELD_DAY:   day_upd = acc_new;
          FIELD_MONTH: month_upd = acc_new;
          default: begin
            year_upd    = acc_new;
            ymod400_nxt = sat ? SAT_MOD400
                              : (9'(ymod40_r) << 3) + (9'(ymod40_r) << 1) + 9'(digit);
            ymod40_nxt  = sat ? SAT_MOD40
                              : (6'(year_r[1:0]) << 3) + (6'(year_r[1:0]) << 1) + 6'(digit);
          end
        endcase
      end else if ((phase_r == PH_BLANK) && is_blank) begin
        phase_nxt = PH_BLANK;
      end else if ((phase_r == PH_BLANK) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        phase_nxt = PH_SIGN;
        if (c == CH_MINUS) begin
          neg_nxt[field_r] = 1'b1;
        end
      end else begin
        phase_nxt = PH_STOP;
      end
    end
  end

  always_comb begin
    flags.dots_ok = field_nxt == FIELD_YEAR;
    flags.neg     = neg_nxt;
    flags.leap    = (ymod400_nxt == 9'd0) ||
                    ((year_upd[1:0] == 2'd0) && (ymod400_nxt != 9'd100) &&
                     (ymod400_nxt != 9'd200) && (ymod400_nxt != 9'd300));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r   <= FIELD_DAY;
      phase_r   <= PH_BLANK;
      day_r     <= '0;
      month_r   <= '0;
      year_r    <= '0;
      neg_r     <= '0;
      ended_r   <= 1'b0;
      ymod400_r <= '0;
      ymod40_r  <= '0;
    end else if (step) begin
      if (item.last_char) begin
        field_r   <= FIELD_DAY;
        phase_r   <= PH_BLANK;
        day_r     <= '0;
        month_r   <= '0;
        year_r    <= '0;
        neg_r     <= '0;
        ended_r   <= 1'b0;
        ymod400_r <= '0;
        ymod40_r  <= '0;
      end else begin
        field_r   <= field_nxt;
        phase_r   <= phase_nxt;
        day_r     <= day_upd;
        month_r   <= month_upd;
        year_r    <= year_upd;
        neg_r     <= neg_nxt;
        ended_r   <= ended_nxt;
        ymod400_r <= ymod400_nxt;
        ymod40_r  <= ymod40_nxt;
      end
    end
  end

endmodule

FILE: rtl/dspv_check.sv
module dspv_check #(
  parameter int VALUE_BITS = dspv_pkg::VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0]                   day_v,
  input  logic [VALUE_BITS-1:0]                   month_v,
  input  logic [VALUE_BITS-1:0]                   year_v,
  input  dspv_pkg::parse_flags_t                  flags,
  input  logic [dspv_pkg::CFG_DATA_BITS-1:0]      min_year,
  input  logic [dspv_pkg::CFG_DATA_BITS-1:0]      max_year,
  output dspv_pkg::out_item_t                     res
);
  import dspv_pkg::*;

  logic [4:0] dpm;
  logic       month_small, neg_bad, ok;

  always_comb begin
    month_small = month_v <= VALUE_BITS'(12);
    dpm = 5'd0;
    if (month_small) begin
      if (month_v[3:0] inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
        dpm = 5'd31;
      end else if (month_v[3:0] inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
        dpm = 5'd30;
      end else if (month_v[3:0] == 4'd2) begin
        dpm = flags.leap ? 5'd29 : 5'd28;
      end
    end
    // a minus sign only hurts when the value is not zero
    neg_bad = (flags.neg[0] && (day_v != '0)) ||
              (flags.neg[1] && (month_v != '0)) ||
              (flags.neg[2] && (year_v != '0));
    ok = flags.dots_ok && !neg_bad && (dpm != 5'd0) && (day_v != '0) &&
         (day_v <= VALUE_BITS'(dpm)) &&
         (year_v >= VALUE_BITS'(min_year)) && (year_v <= VALUE_BITS'(max_year));
    res.valid_res = ok;
    res.day       = ok ? day_v[4:0] : 5'd0;
    res.month     = ok ? month_v[3:0] : 4'd0;
    res.year      = ok ? year_v[11:0] : 12'd0;
  end

endmodule

FILE: rtl/date_string_parse_validate_top.sv
// a result is stored in the result register as the last character leaves the input register
// throughput: one character per cycle while no last character waits for the result register
// the output register lets characters that end no text keep flowing while a result waits
// reset: synchronous, active low; clears parse state, pipeline valids, year range to 1900..2199
module date_string_parse_validate_top #(
  parameter int VALUE_BITS = dspv_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dspv_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dspv_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [dspv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [dspv_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import dspv_pkg::*;

  // input register
  logic     in_v_r;
  in_item_t in_item_r;

  // result register
  logic      out_v_r;
  out_item_t out_item_r;
  out_item_t res;

  // year range registers
  logic [CFG_DATA_BITS-1:0] min_year_r, max_year_r;

  logic                  advance, in_take, out_take;
  logic [VALUE_BITS-1:0] day_upd, month_upd, year_upd;
  parse_flags_t          flags;

  // a character that ends a text needs room in the result register;
  // any other character moves on regardless of the output side
  assign out_take = out_v_r && !out_stall;
  assign advance  = in_v_r && (!in_item_r.last_char || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_v_r || advance) begin
      in_v_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // character stage: accumulators and sign and field tracking
  dspv_parse #(
    .VALUE_BITS(VALUE_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (in_item_r),
    .day_upd  (day_upd),
    .month_upd(month_upd),
    .year_upd (year_upd),
    .flags    (flags)
  );

  // calendar and range check on the state after this character
  dspv_check #(
    .VALUE_BITS(VALUE_BITS)
  ) u_check (
    .day_v   (day_upd),
    .month_v (month_upd),
    .year_v  (year_upd),
    .flags   (flags),
    .min_year(min_year_r),
    .max_year(max_year_r),
    .res     (res)
  );

  // result register, refilled in the cycle it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && in_item_r.last_char) begin
      out_v_r <= 1'b1;
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item_r.last_char) begin
      out_item_r <= res;
    end
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MIN_YEAR) begin
        min_year_r <= cfg_data;
      end else if (cfg_index == REG_MAX_YEAR) begin
        max_year_r <= cfg_data;
      end
    end
  end

endmodule
